@@ hw/rtl/scr_pkg.sv @@
// Shared types, constants and table functions for the spherical rotation pipeline.
`default_nettype none

package scr_pkg;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int TRIG_ITER_DEF  = 30;

  // Q1.30 trig values with headroom for sums of several terms
  localparam int VAL_W = 36;
  typedef logic signed [VAL_W-1:0] val_t;
  localparam val_t ONE = val_t'(64'sd1073741824);

  // restoring square root: one result bit per stage
  localparam int SQ_STEPS = 31;
  localparam int SQ_W     = 62;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_POLE_LON = 2'd0,
    REG_POLE_LAT = 2'd1,
    REG_ORIG_LON = 2'd2,
    REG_ORIG_LAT = 2'd3
  } reg_idx_e;

  // rounded Q1.30 product
  function automatic val_t qmul(input val_t a, input val_t b);
    logic signed [2*VAL_W-1:0] p;
    p = a * b + (72'sd1 <<< 29);
    return val_t'(p >>> 30);
  endfunction

  // shift-and-subtract unsigned division, used for table constants only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // integer square root, used for the gain constant
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC start value K in Q1.30
  function automatic logic [63:0] cordic_gain(input int iters);
    logic [63:0] p;
    logic [63:0] s;
    p = 64'd1 << 62;
    for (int i = 0; i < iters; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    s = isqrt64(p);
    return udiv64((64'd1 << 61) + (s >> 1), s);
  endfunction

  // step angle atan(2^-i) as a binary angle of ab bits
  function automatic logic [63:0] atan_entry(input int i, input int ab);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           k;
    if (i == 0) return 64'd1 << (ab - 3);
    rad = '0;
    k   = 0;
    while (i * (2 * k + 1) <= 62) begin
      term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) rad = rad - term;
      else rad = rad + term;
      k++;
    end
    prod = 128'(rad) * 128'(64'hA2F9_836E_4E44_152A);
    return (prod[127:64] + (64'd1 << (63 - ab))) >> (64 - ab);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scr_sincos.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
`default_nettype none

module scr_sincos #(
  parameter int ANGLE_BITS      = scr_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = scr_pkg::TRIG_ITER_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output scr_pkg::val_t         cos_o,
  output scr_pkg::val_t         sin_o
);
  import scr_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int IT = TRIG_ITERATIONS;
  localparam val_t GAIN = val_t'(cordic_gain(IT));

  val_t                 x_q    [IT+1];
  val_t                 y_q    [IT+1];
  logic signed [AB-1:0] z_q    [IT+1];
  logic [1:0]           quad_q [IT+1];
  logic                 zero_q [IT+1];
  val_t                 cx, cy;
  val_t                 cos_q, sin_q;

  // quadrant split and start vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= signed'({2'b00, angle_i[AB-3:0]});
      quad_q[0] <= angle_i[AB-1:AB-2];
      zero_q[0] <= (angle_i[AB-3:0] == '0);
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < IT; i++) begin : g_step
    localparam logic signed [AB-1:0] STEP = AB'(atan_entry(i, AB));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - STEP;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + STEP;
        end
        quad_q[i+1] <= quad_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // exact axis case, then quadrant mapping
  always_comb begin
    cx = zero_q[IT] ? ONE : x_q[IT];
    cy = zero_q[IT] ? '0 : y_q[IT];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[IT])
        2'd0: begin cos_q <= cx;  sin_q <= cy;  end
        2'd1: begin cos_q <= -cy; sin_q <= cx;  end
        2'd2: begin cos_q <= -cx; sin_q <= -cy; end
        default: begin cos_q <= cy; sin_q <= -cx; end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

@@ hw/rtl/scr_vecang.sv @@
// Pipelined vectoring-mode CORDIC giving atan2(y, x) as a binary angle.
`default_nettype none

module scr_vecang #(
  parameter int ANGLE_BITS      = scr_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = scr_pkg::TRIG_ITER_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  scr_pkg::val_t         y_i,
  input  scr_pkg::val_t         x_i,
  output logic [ANGLE_BITS-1:0] angle_o
);
  import scr_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int IT = TRIG_ITERATIONS;
  localparam int XW = VAL_W + 2;
  localparam int ZW = AB + 2;
  localparam logic signed [ZW-1:0] HALF = {3'b001, {(AB-1){1'b0}}};

  logic signed [XW-1:0] x_q [IT+1];
  logic signed [XW-1:0] y_q [IT+1];
  logic signed [ZW-1:0] z_q [IT+1];

  // half-turn pre-rotation for the left half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -XW'(x_i);
        y_q[0] <= -XW'(y_i);
        z_q[0] <= HALF;
      end else begin
        x_q[0] <= XW'(x_i);
        y_q[0] <= XW'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  // drive y toward zero, one step per stage
  for (genvar i = 0; i < IT; i++) begin : g_step
    localparam logic signed [ZW-1:0] STEP = ZW'(atan_entry(i, AB));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + STEP;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - STEP;
        end
      end
    end
  end

  assign angle_o = z_q[IT][AB-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/spherical_coordinate_rotation.sv @@
// Top level: config registers, trig pipelines, products, square root, output stage.
// Throughput: one point per cycle while no result waits for tready; the whole pipe is one
// chain of CORDIC, multiply and square-root stages, each a single register stage.
// A result held at the output without tready freezes every stage; nothing is dropped.
// Reset clears all valid bits and loads the configuration registers with their reset values.
`default_nettype none

module spherical_coordinate_rotation #(
  parameter int ANGLE_BITS      = scr_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = scr_pkg::TRIG_ITER_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input point
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // point_latitude [63:32], point_longitude [31:0]
  // result
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // new_latitude [63:32], new_longitude [31:0]
  output logic                       m_axis_tuser,  // degenerate
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import scr_pkg::*;

  localparam int AB      = ANGLE_BITS;
  localparam int IT      = TRIG_ITERATIONS;
  localparam int SC_LAT  = IT + 2;
  localparam int VA_LAT  = IT + 1;
  localparam int LAT     = SC_LAT + VA_LAT + SQ_STEPS + 7;
  localparam int P2_IDX  = SC_LAT + 1;
  localparam int Q1_IDX  = SC_LAT + 5 + SQ_STEPS;
  localparam int SC_B1   = 0;
  localparam int SC_BP   = 1;
  localparam int SC_BO   = 2;
  localparam int SC_DA   = 3;
  localparam int SC_DO   = 4;
  localparam int SC_N    = 5;
  localparam logic signed [2*VAL_W-1:0] ONE_SQ = 72'sd1 <<< 60;

  function automatic logic [AB-1:0] to_ang(input logic [31:0] v);
    logic [AB+31:0] w;
    w = {v, {AB{1'b0}}};
    return w[AB+31:32];
  endfunction

  function automatic logic [31:0] from_ang(input logic [AB-1:0] a);
    logic [AB+31:0] w;
    w = {a, 32'd0};
    return w[AB+31:AB];
  endfunction

  logic [31:0] pole_lon_q, pole_lat_q, orig_lon_q, orig_lat_q;
  logic        cfg_wr;
  logic        en;
  logic [LAT-1:0] vld_q;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_lon_q <= 32'h0000_0000;
      pole_lat_q <= 32'h4000_0000;
      orig_lon_q <= 32'h0000_0000;
      orig_lat_q <= 32'h0000_0000;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_POLE_LON: pole_lon_q <= pwdata;
        REG_POLE_LAT: pole_lat_q <= pwdata;
        REG_ORIG_LON: orig_lon_q <= pwdata;
        default:      orig_lat_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_POLE_LON: prdata = pole_lon_q;
      REG_POLE_LAT: prdata = pole_lat_q;
      REG_ORIG_LON: prdata = orig_lon_q;
      default:      prdata = orig_lat_q;
    endcase
  end

  // global advance: a held result stalls everything
  assign en            = ~vld_q[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // five sine/cosine pipelines
  logic [AB-1:0] sc_ang [SC_N];
  val_t          sc_cos [SC_N];
  val_t          sc_sin [SC_N];
  logic [AB-1:0] plon_a;

  assign plon_a        = to_ang(pole_lon_q);
  assign sc_ang[SC_B1] = to_ang(s_axis_tdata[63:32]);
  assign sc_ang[SC_BP] = to_ang(pole_lat_q);
  assign sc_ang[SC_BO] = to_ang(orig_lat_q);
  assign sc_ang[SC_DA] = plon_a - to_ang(s_axis_tdata[31:0]);
  assign sc_ang[SC_DO] = plon_a - to_ang(orig_lon_q);

  for (genvar j = 0; j < SC_N; j++) begin : g_sc
    scr_sincos #(
      .ANGLE_BITS      (AB),
      .TRIG_ITERATIONS (IT)
    ) u_sincos (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (sc_ang[j]),
      .cos_o   (sc_cos[j]),
      .sin_o   (sc_sin[j])
    );
  end

  // P1: first products
  val_t p1_t1_q, p1_t2_q, p1_sa_q, p1_cc_q, p1_sbb_q;
  val_t p1_cda_q, p1_sb1_q, p1_sbp_q, p1_sbo_q, p1_cbp_q;
  logic p1_cbpz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_t1_q   <= qmul(sc_sin[SC_BP], sc_sin[SC_B1]);
      p1_t2_q   <= qmul(sc_cos[SC_BP], sc_cos[SC_B1]);
      p1_sa_q   <= qmul(sc_sin[SC_DA], sc_cos[SC_B1]);
      p1_cc_q   <= qmul(sc_cos[SC_BP], sc_cos[SC_BP]);
      p1_sbb_q  <= qmul(sc_sin[SC_DO], sc_cos[SC_BO]);
      p1_cda_q  <= sc_cos[SC_DA];
      p1_sb1_q  <= sc_sin[SC_B1];
      p1_sbp_q  <= sc_sin[SC_BP];
      p1_sbo_q  <= sc_sin[SC_BO];
      p1_cbp_q  <= sc_cos[SC_BP];
      p1_cbpz_q <= (sc_cos[SC_BP] == '0);
    end
  end

  // P2: sine of new latitude, saturated to the range -1 to 1
  val_t p2_sum;
  val_t p2_sb2_q, p2_st_q, p2_sb1_q, p2_sbp_q, p2_sbo_q, p2_cbp_q, p2_cc_q, p2_sbb_q;
  logic p2_cbpz_q;

  assign p2_sum = p1_t1_q + qmul(p1_t2_q, p1_cda_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (p2_sum > ONE) p2_sb2_q <= ONE;
      else if (p2_sum < -ONE) p2_sb2_q <= -ONE;
      else p2_sb2_q <= p2_sum;
      p2_st_q   <= qmul(p1_sa_q, p1_cbp_q);
      p2_sb1_q  <= p1_sb1_q;
      p2_sbp_q  <= p1_sbp_q;
      p2_sbo_q  <= p1_sbo_q;
      p2_cbp_q  <= p1_cbp_q;
      p2_cc_q   <= p1_cc_q;
      p2_sbb_q  <= p1_sbb_q;
      p2_cbpz_q <= p1_cbpz_q;
    end
  end

  // P3: cosine term and radicand for cos(b2)
  logic signed [2*VAL_W-1:0] p3_sq;
  val_t             p3_ct_q, p3_sb2_q, p3_st_q, p3_sbo_q, p3_cbp_q, p3_cc_q, p3_sbb_q;
  logic [SQ_W-1:0]  p3_rad_q;
  logic             p3_cbpz_q;

  assign p3_sq = p2_sb2_q * p2_sb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_ct_q   <= p2_sb1_q - qmul(p2_sb2_q, p2_sbp_q);
      p3_rad_q  <= SQ_W'(ONE_SQ - p3_sq);
      p3_sb2_q  <= p2_sb2_q;
      p3_st_q   <= p2_st_q;
      p3_sbo_q  <= p2_sbo_q;
      p3_cbp_q  <= p2_cbp_q;
      p3_cc_q   <= p2_cc_q;
      p3_sbb_q  <= p2_sbb_q;
      p3_cbpz_q <= p2_cbpz_q;
    end
  end

  // P4: cross products
  val_t            p4_u1_q, p4_u2_q, p4_m2_q, p4_d1_q, p4_sb2_q, p4_cbp_q, p4_cc_q;
  logic [SQ_W-1:0] p4_rad_q;
  logic            p4_cbpz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_u1_q   <= qmul(p3_st_q, p3_sbb_q);
      p4_u2_q   <= qmul(p3_ct_q, p3_sbb_q);
      p4_m2_q   <= qmul(p3_ct_q, p3_sbo_q);
      p4_d1_q   <= qmul(p3_st_q, p3_sbo_q);
      p4_sb2_q  <= p3_sb2_q;
      p4_cbp_q  <= p3_cbp_q;
      p4_cc_q   <= p3_cc_q;
      p4_rad_q  <= p3_rad_q;
      p4_cbpz_q <= p3_cbpz_q;
    end
  end

  // P5: denominator and the part of the numerator without cos(b2)
  val_t            p5_den_q, p5_np_q, p5_sb2_q, p5_cc_q;
  logic [SQ_W-1:0] p5_rad_q;
  logic            p5_cbpz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_den_q  <= p4_d1_q - qmul(p4_u2_q, p4_cbp_q);
      p5_np_q   <= -p4_m2_q - qmul(p4_u1_q, p4_cbp_q);
      p5_sb2_q  <= p4_sb2_q;
      p5_cc_q   <= p4_cc_q;
      p5_rad_q  <= p4_rad_q;
      p5_cbpz_q <= p4_cbpz_q;
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0] sq_n_q    [SQ_STEPS];
  logic [SQ_W-1:0] sq_r_q    [SQ_STEPS];
  val_t            sq_sb2_q  [SQ_STEPS];
  val_t            sq_cc_q   [SQ_STEPS];
  val_t            sq_np_q   [SQ_STEPS];
  val_t            sq_den_q  [SQ_STEPS];
  logic            sq_cbpz_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] n_in, r_in, trial;
    val_t            sb2_in, cc_in, np_in, den_in;
    logic            cbpz_in;

    if (k == 0) begin : g_first
      assign n_in    = p5_rad_q;
      assign r_in    = '0;
      assign sb2_in  = p5_sb2_q;
      assign cc_in   = p5_cc_q;
      assign np_in   = p5_np_q;
      assign den_in  = p5_den_q;
      assign cbpz_in = p5_cbpz_q;
    end else begin : g_next
      assign n_in    = sq_n_q[k-1];
      assign r_in    = sq_r_q[k-1];
      assign sb2_in  = sq_sb2_q[k-1];
      assign cc_in   = sq_cc_q[k-1];
      assign np_in   = sq_np_q[k-1];
      assign den_in  = sq_den_q[k-1];
      assign cbpz_in = sq_cbpz_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (n_in >= trial) begin
          sq_n_q[k] <= n_in - trial;
          sq_r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          sq_n_q[k] <= n_in;
          sq_r_q[k] <= r_in >> 1;
        end
        sq_sb2_q[k]  <= sb2_in;
        sq_cc_q[k]   <= cc_in;
        sq_np_q[k]   <= np_in;
        sq_den_q[k]  <= den_in;
        sq_cbpz_q[k] <= cbpz_in;
      end
    end
  end

  // Q1: numerator and degenerate flag
  val_t q1_cb2;
  val_t q1_cb2_q, q1_sb2_q, q1_num_q, q1_den_q;
  logic q1_dg_q;

  assign q1_cb2 = val_t'(sq_r_q[SQ_STEPS-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_cb2_q <= q1_cb2;
      q1_sb2_q <= sq_sb2_q[SQ_STEPS-1];
      q1_num_q <= qmul(q1_cb2, sq_cc_q[SQ_STEPS-1]) + sq_np_q[SQ_STEPS-1];
      q1_den_q <= sq_den_q[SQ_STEPS-1];
      q1_dg_q  <= (q1_cb2 == '0) | sq_cbpz_q[SQ_STEPS-1] |
                  (sq_den_q[SQ_STEPS-1] == '0);
    end
  end

  // angle pipelines for latitude and half longitude
  logic [AB-1:0] lat_ang, hlon_ang;
  logic          dg_q [VA_LAT];

  scr_vecang #(
    .ANGLE_BITS      (AB),
    .TRIG_ITERATIONS (IT)
  ) u_vec_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (q1_sb2_q),
    .x_i     (q1_cb2_q),
    .angle_o (lat_ang)
  );

  scr_vecang #(
    .ANGLE_BITS      (AB),
    .TRIG_ITERATIONS (IT)
  ) u_vec_lon (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (q1_num_q),
    .x_i     (q1_den_q),
    .angle_o (hlon_ang)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q[0] <= q1_dg_q;
      for (int d = 1; d < VA_LAT; d++) dg_q[d] <= dg_q[d-1];
    end
  end

  // output register
  logic [31:0] out_lon_q, out_lat_q;
  logic        out_dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_lon_q <= dg_q[VA_LAT-1] ? 32'd0 : from_ang({hlon_ang[AB-2:0], 1'b0});
      out_lat_q <= from_ang(lat_ang);
      out_dg_q  <= dg_q[VA_LAT-1];
    end
  end

  assign m_axis_tdata = {out_lat_q, out_lon_q};
  assign m_axis_tuser = out_dg_q;

  // checks
  a_dg_lon_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
    else $error("degenerate result with nonzero longitude");

  a_sb2_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P2_IDX] |-> (p2_sb2_q <= ONE) && (p2_sb2_q >= -ONE))
    else $error("sine of new latitude out of range");

  a_cb2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Q1_IDX] |-> (q1_cb2_q >= 0) && (q1_cb2_q <= ONE))
    else $error("cos of new latitude out of range");

endmodule

`default_nettype wire
